/* hdl/ubx_position_frame_parser_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the UBX position frame parser
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef UBX_POSITION_FRAME_PARSER_UNIT_MACROS_SVH
`define UBX_POSITION_FRAME_PARSER_UNIT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define UBX_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property on every clock edge, including the reset cycles.
`define UBX_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/ubx_pkg.sv */
// ----------------------------------------------------------------------------
// UBX position frame parser package
// Shared constants, types and helpers of the parser.
// ----------------------------------------------------------------------------
package ubx_pkg;

   localparam int PAYLOAD_LEN = 92;
   localparam int HDR_LEN     = 6;
   localparam int NUM_FIELDS  = 19;

   localparam logic [6:0] POS_SUM_A = 7'd98;
   localparam logic [6:0] POS_SUM_B = 7'd99;

   localparam logic [7:0] STUCK_LIMIT_RESET = 8'd20;

   typedef logic [6:0] addr_type;

   // Header byte expected at each header position.
   function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
      logic [7:0] b;
      case (pos)
         3'd0:    b = 8'hB5;
         3'd1:    b = 8'h62;
         3'd2:    b = 8'h01;
         3'd3:    b = 8'h07;
         3'd4:    b = 8'h5C;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Per field: payload offset of the first byte, byte count, and sign.
   typedef struct packed {
      logic [6:0] offset;
      logic [2:0] nbytes;
      logic       sext;
   } fdesc_type;

   function automatic fdesc_type field_desc(input logic [4:0] id);
      fdesc_type d;
      d.sext = 1'b0;
      d.nbytes = 3'd4;
      case (id)
         5'd0:    d.offset = 7'd0;
         5'd1:    begin d.offset = 7'd4;  d.nbytes = 3'd2; end
         5'd2:    begin d.offset = 7'd6;  d.nbytes = 3'd1; end
         5'd3:    begin d.offset = 7'd7;  d.nbytes = 3'd1; end
         5'd4:    begin d.offset = 7'd8;  d.nbytes = 3'd1; end
         5'd5:    begin d.offset = 7'd9;  d.nbytes = 3'd1; end
         5'd6:    begin d.offset = 7'd10; d.nbytes = 3'd1; end
         5'd7:    begin d.offset = 7'd20; d.nbytes = 3'd1; end
         5'd8:    begin d.offset = 7'd23; d.nbytes = 3'd1; end
         5'd9:    d.offset = 7'd24;
         5'd10:   d.offset = 7'd28;
         5'd11:   d.offset = 7'd36;
         5'd12:   d.offset = 7'd48;
         5'd13:   d.offset = 7'd52;
         5'd14:   d.offset = 7'd56;
         5'd15:   d.offset = 7'd60;
         5'd16:   d.offset = 7'd64;
         5'd17:   begin d.offset = 7'd76; d.nbytes = 3'd2; d.sext = 1'b1; end
         default: begin d.offset = 7'd0;  d.nbytes = 3'd0; end
      endcase
      return d;
   endfunction

endpackage

/* hdl/ubx_payload_ram.sv */
// ----------------------------------------------------------------------------
// UBX payload memory
// Single-port-write, single-read synchronous byte memory with a registered read.
// ----------------------------------------------------------------------------
module ubx_payload_ram #(
   parameter int DEPTH = 92
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);
   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/ubx_course_div.sv */
// ----------------------------------------------------------------------------
// UBX course divider
// Signed 32-bit division by 10000, truncated toward zero, by reciprocal
// multiplication of the magnitude: the magnitude is registered, then the product.
// ----------------------------------------------------------------------------
module ubx_course_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   output logic        busy,
   output logic [31:0] quotient
);
   // For every magnitude below 2^32, m / 10000 equals (m * RECIP) >> 45.
   localparam logic [31:0] RECIP = 32'hD1B71759;

   logic        busy_ff, busy_in;
   logic [31:0] mag_ff,  mag_in;
   logic        neg_ff,  neg_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] q_mag;

   always_comb begin
      busy_in = 1'b0;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      prod_in = prod_ff;
      if (start) begin
         neg_in  = dividend[31];
         mag_in  = dividend[31] ? (~dividend + 32'd1) : dividend;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = 64'(mag_ff) * 64'(RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
   end

   assign q_mag    = {13'd0, prod_ff[63:45]};
   assign busy     = busy_ff;
   assign quotient = neg_ff ? (~q_mag + 32'd1) : q_mag;
endmodule

/* hdl/ubx_position_frame_parser_unit.sv */
// ----------------------------------------------------------------------------
// UBX position frame parser
// Hunts navigation frames in a byte stream, checks their Fletcher sums and
// emits nineteen tagged fields for each good frame.
// ----------------------------------------------------------------------------
//  Channel | Direction | Ports
//  req     | in        | req_valid, req_stall, req_rx_byte
//  rsp     | out       | rsp_valid, rsp_stall, rsp_field_id, rsp_field_value,
//          |           | rsp_last_of_frame
//  csr     | in/out    | APB: psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A byte is taken whenever req_valid is high while a frame is being collected.
// After the second sum byte of a good frame the block stops taking bytes and
// emits its results: each field is gathered from the payload memory one byte
// per cycle and then loaded into the result register; the course first passes
// through the divider, and the stuck flag needs no memory read. Output stalls
// hold back the results.
// Reset is synchronous and active high; the payload memory is not cleared.
// A stall on the result channel holds the result register and the sequencer.
// ----------------------------------------------------------------------------
module ubx_position_frame_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_field_id,
   output logic signed [31:0] rsp_field_value,
   output logic        rsp_last_of_frame,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ubx_pkg::*;
   `include "ubx_position_frame_parser_unit_macros.svh"

   localparam int AW = $clog2(PAYLOAD_LEN);

   localparam logic [2:0] ST_RX    = 3'd0;  // collecting bytes
   localparam logic [2:0] ST_FETCH = 3'd1;  // reading field bytes
   localparam logic [2:0] ST_DIV   = 3'd2;  // waiting on the divider
   localparam logic [2:0] ST_OUT   = 3'd3;  // result register loaded, next field

   // Configuration register.
   logic [7:0] stuck_limit_ff;
   logic       csr_wr;
   assign csr_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign prdata = (paddr == 2'd0) ? {24'd0, stuck_limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         stuck_limit_ff <= STUCK_LIMIT_RESET;
      end else if (csr_wr && paddr == 2'd0) begin
         stuck_limit_ff <= pwdata[7:0];
      end
   end

   // Control and frame state.
   logic [2:0]  state_ff,   state_in;
   logic [6:0]  pos_ff,     pos_in;
   logic [7:0]  sum_a_ff,   sum_a_in;
   logic [7:0]  sum_b_ff,   sum_b_in;
   logic [4:0]  fid_ff,     fid_in;
   logic [2:0]  bcnt_ff,    bcnt_in;   // bytes requested for current field
   logic        rd_pend_ff, rd_pend_in;
   logic [31:0] acc_ff,     acc_in;
   logic [31:0] lon_ff,     lon_in;
   logic [31:0] last_lon_ff, last_lon_in;
   logic [31:0] last_lat_ff, last_lat_in;
   logic [7:0]  scnt_ff,    scnt_in;
   logic        sflag_ff,   sflag_in;
   logic        ovalid_ff,  ovalid_in;
   logic [4:0]  oid_ff,     oid_in;
   logic [31:0] oval_ff,    oval_in;
   logic        olast_ff,   olast_in;
   logic        div_started_ff, div_started_in;

   logic        take;
   logic        ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [7:0]  ram_rd;
   logic        div_start, div_busy;
   logic [31:0] div_q;
   fdesc_type   desc;
   logic [31:0] fval;
   logic        out_free;
   logic [8:0]  cnt_inc;
   logic        rsp_held;
   logic [37:0] rsp_bus;

   assign desc      = field_desc(fid_ff);
   assign req_stall = (state_ff != ST_RX);
   assign take      = req_valid && !req_stall;
   assign out_free  = !ovalid_ff || !rsp_stall;
   assign ram_we    = take && pos_ff >= 7'(HDR_LEN) && pos_ff < POS_SUM_A;
   assign ram_wa    = AW'(pos_ff - 7'(HDR_LEN));
   assign ram_ra    = AW'(desc.offset + 7'(bcnt_ff));
   assign cnt_inc   = {1'b0, scnt_ff} + 9'd1;

   ubx_payload_ram #(.DEPTH(PAYLOAD_LEN)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(req_rx_byte),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   ubx_course_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(acc_ff),
      .busy(div_busy), .quotient(div_q)
   );

   // Gathered value, extended by field size.
   always_comb begin
      case (desc.nbytes)
         3'd1:    fval = {24'd0, acc_ff[31:24]};
         3'd2:    fval = desc.sext ? {{16{acc_ff[31]}}, acc_ff[31:16]}
                                   : {16'd0, acc_ff[31:16]};
         default: fval = acc_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;  pos_in = pos_ff;  sum_a_in = sum_a_ff;  sum_b_in = sum_b_ff;
      fid_in = fid_ff;  bcnt_in = bcnt_ff;  rd_pend_in = 1'b0;  acc_in = acc_ff;
      lon_in = lon_ff;  last_lon_in = last_lon_ff;  last_lat_in = last_lat_ff;
      scnt_in = scnt_ff;  sflag_in = sflag_ff;
      ovalid_in = ovalid_ff && rsp_stall;
      oid_in = oid_ff;  oval_in = oval_ff;  olast_in = olast_ff;
      div_start = 1'b0;  div_started_in = div_started_ff;
      case (state_ff)
         ST_RX: begin
            if (take) begin
               if (pos_ff < 7'(HDR_LEN)) begin
                  if (req_rx_byte == hdr_byte(pos_ff[2:0])) begin
                     if (pos_ff == 7'd0) begin
                        sum_a_in = '0;  sum_b_in = '0;
                     end else if (pos_ff >= 7'd2) begin
                        sum_a_in = sum_a_ff + req_rx_byte;
                        sum_b_in = sum_b_ff + sum_a_in;
                     end
                     pos_in = pos_ff + 7'd1;
                  end else begin
                     pos_in = (req_rx_byte == hdr_byte(3'd0)) ? 7'd1 : 7'd0;
                     sum_a_in = '0;  sum_b_in = '0;
                  end
               end else if (pos_ff < POS_SUM_A) begin
                  sum_a_in = sum_a_ff + req_rx_byte;
                  sum_b_in = sum_b_ff + sum_a_in;
                  pos_in = pos_ff + 7'd1;
               end else if (pos_ff == POS_SUM_A) begin
                  sum_a_in = sum_a_ff ^ req_rx_byte;
                  pos_in = POS_SUM_B;
               end else begin
                  pos_in = '0;  sum_a_in = '0;  sum_b_in = '0;
                  if (sum_a_ff == 8'd0 && sum_b_ff == req_rx_byte) begin
                     state_in = ST_FETCH;
                     fid_in = '0;  bcnt_in = '0;  div_started_in = 1'b0;
                  end
               end
            end
         end
         ST_FETCH: begin
            // Read address issued this cycle; data of the previous read lands.
            if (rd_pend_ff) begin
               acc_in = {ram_rd, acc_ff[31:8]};
            end
            if (bcnt_ff != desc.nbytes) begin
               bcnt_in = bcnt_ff + 3'd1;
               rd_pend_in = 1'b1;
            end else if (!rd_pend_ff) begin
               if (fid_ff == 5'd16 && !div_started_ff) begin
                  div_start = 1'b1;
                  div_started_in = 1'b1;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_DIV: begin
            if (!div_busy) state_in = ST_OUT;
         end
         default: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               oid_in = fid_ff;
               olast_in = (fid_ff == 5'(NUM_FIELDS - 1));
               case (fid_ff)
                  5'd9:  begin oval_in = fval;  lon_in = fval; end
                  5'd10: begin
                     oval_in = fval;
                     if (lon_ff == last_lon_ff && fval == last_lat_ff && lon_ff != 32'd0) begin
                        if (cnt_inc >= {1'b0, stuck_limit_ff}) begin
                           scnt_in = stuck_limit_ff;
                           sflag_in = 1'b1;
                        end else begin
                           scnt_in = cnt_inc[7:0];
                        end
                     end else begin
                        scnt_in = '0;
                        sflag_in = 1'b0;
                     end
                     last_lon_in = lon_ff;
                     last_lat_in = fval;
                  end
                  5'd16:   oval_in = div_q;
                  5'd18:   oval_in = {31'd0, sflag_ff};
                  default: oval_in = fval;
               endcase
               bcnt_in = '0;
               if (fid_ff == 5'(NUM_FIELDS - 1)) begin
                  state_in = ST_RX;
               end else begin
                  fid_in = fid_ff + 5'd1;
                  state_in = ST_FETCH;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RX;  pos_ff <= '0;  sum_a_ff <= '0;  sum_b_ff <= '0;
         rd_pend_ff <= 1'b0;  last_lon_ff <= '0;  last_lat_ff <= '0;
         scnt_ff <= '0;  sflag_ff <= 1'b0;  ovalid_ff <= 1'b0;  div_started_ff <= 1'b0;
      end else begin
         state_ff <= state_in;  pos_ff <= pos_in;  sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;  rd_pend_ff <= rd_pend_in;  last_lon_ff <= last_lon_in;
         last_lat_ff <= last_lat_in;  scnt_ff <= scnt_in;  sflag_ff <= sflag_in;
         ovalid_ff <= ovalid_in;  div_started_ff <= div_started_in;
      end
      fid_ff <= fid_in;  bcnt_ff <= bcnt_in;  acc_ff <= acc_in;  lon_ff <= lon_in;
      oid_ff <= oid_in;  oval_ff <= oval_in;  olast_ff <= olast_in;
   end

   assign rsp_valid         = ovalid_ff;
   assign rsp_field_id      = oid_ff;
   assign rsp_field_value   = oval_ff;
   assign rsp_last_of_frame = olast_ff;

   assign rsp_held = rsp_valid && rsp_stall;
   assign rsp_bus  = {rsp_field_id, rsp_field_value, rsp_last_of_frame};

   // Bytes are never taken while a frame's results are being produced.
   `UBX_ASSERT(a_no_take_busy, clock, reset, (state_ff != ST_RX) |-> !take, "byte taken while busy")
   // A held result must stay put under stall.
   `UBX_ASSERT(a_hold, clock, reset, rsp_held |=> $stable(rsp_bus), "result changed under stall")
   // The frame counter never passes the second sum byte.
   `UBX_ASSERT(a_pos_range, clock, reset, (pos_ff <= POS_SUM_B), "frame position out of range")
   // The configuration port never inserts wait states.
   `UBX_ASSERT_ALWAYS(a_pready, clock, pready, "configuration port not ready")
endmodule
